/* rtl/etbs_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Exponential search package
// Types and constants shared by the front end, the search engine and the top.
// ---------------------------------------------------------------------------
package etbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int EXT_W       = IDX_W + 1;
   localparam int POS_W       = 10;
   localparam int DATA_W      = 32;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [POS_W-1:0]          index;
      logic signed [DATA_W-1:0]  data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

endpackage
`default_nettype wire

/* rtl/etbs_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Exponential search front end
// Accepts command beats, drops loads beyond the table and queues the rest.
// ---------------------------------------------------------------------------
module etbs_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_kind,
   input  wire logic [etbs_pkg::POS_W-1:0]       req_entry_index,
   input  wire logic signed [etbs_pkg::DATA_W-1:0] req_entry_value,
   input  wire logic signed [etbs_pkg::DATA_W-1:0] req_search_key,
   output etbs_pkg::queue_type                   queue_out,
   input  wire logic                             queue_pop
);
   import etbs_pkg::*;

   item_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept;
   logic                push;
   logic                do_pop;
   item_type            new_item;

   assign busy   = (count_ff == QCNT_W'(QDEPTH));
   assign accept = start && !busy;

   always_comb begin
      new_item.op    = op_type'(req_kind);
      new_item.index = req_entry_index;
      new_item.data  = (req_kind == OP_SEARCH) ? req_search_key : req_entry_value;
   end

   assign push   = accept &&
                   !((new_item.op == OP_LOAD) && (32'(req_entry_index) >= TABLE_DEPTH));
   assign do_pop = queue_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = QCNT_W'(count_ff + QCNT_W'(push) - QCNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_comb begin
      queue_out.valid = (count_ff != '0);
      queue_out.item  = slot_ff[rd_ptr_ff];
   end

endmodule
`default_nettype wire

/* rtl/etbs_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Exponential search engine
// Holds the sorted table and runs the doubling and halving phases of a search.
// ---------------------------------------------------------------------------
module etbs_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire etbs_pkg::queue_type          queue_in,
   output logic                              queue_pop,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [etbs_pkg::POS_W-1:0]        rsp_position
);
   import etbs_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EXP_RD  = 5'b00010,
      ST_EXP_CMP = 5'b00100,
      ST_BIN_RD  = 5'b01000,
      ST_BIN_CMP = 5'b10000
   } state_type;

   logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;

   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]         start_ff, start_in;
   logic [EXT_W-1:0]         end_ff, end_in;
   logic [EXT_W-1:0]         low_ff, low_in;
   logic [EXT_W-1:0]         high_ff, high_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic                     strobe_ff, strobe_in;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         pos_ff, pos_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         addr_a;
   logic [IDX_W-1:0]         addr_b;
   logic [EXT_W+1:0]         mid_sum;
   logic [EXT_W:0]           next_end;

   assign mid_sum  = (EXT_W+2)'(low_ff) + (EXT_W+2)'(high_ff) - (EXT_W+2)'(1);
   assign next_end = {end_ff, 1'b1};
   assign addr_a   = (state_ff == ST_BIN_RD) ? IDX_W'(mid_sum >> 1) : start_ff;
   assign addr_b   = end_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      mid_in    = mid_ff;
      strobe_in = 1'b0;
      found_in  = found_ff;
      pos_in    = pos_ff;
      queue_pop = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_in.valid) begin
               queue_pop = 1'b1;
               if (queue_in.item.op == OP_LOAD) begin
                  wr_en = 1'b1;
               end else begin
                  key_in   = queue_in.item.data;
                  start_in = '0;
                  end_in   = EXT_W'(1);
                  state_in = ST_EXP_RD;
               end
            end
         end
         ST_EXP_RD: begin
            state_in = ST_EXP_CMP;
         end
         ST_EXP_CMP: begin
            if ((rd_a_ff <= key_ff) && (key_ff < rd_b_ff)) begin
               low_in   = EXT_W'(start_ff);
               high_in  = end_ff;
               state_in = ST_BIN_RD;
            end else if (next_end >= (EXT_W+1)'(TABLE_DEPTH)) begin
               strobe_in = 1'b1;
               found_in  = 1'b0;
               pos_in    = '0;
               state_in  = ST_IDLE;
            end else begin
               start_in = end_ff[IDX_W-1:0];
               end_in   = next_end[EXT_W-1:0];
               state_in = ST_EXP_RD;
            end
         end
         ST_BIN_RD: begin
            if (low_ff < high_ff) begin
               mid_in   = IDX_W'(mid_sum >> 1);
               state_in = ST_BIN_CMP;
            end else begin
               strobe_in = 1'b1;
               found_in  = 1'b0;
               pos_in    = '0;
               state_in  = ST_IDLE;
            end
         end
         ST_BIN_CMP: begin
            if (key_ff < rd_a_ff) begin
               high_in  = EXT_W'(mid_ff);
               state_in = ST_BIN_RD;
            end else if (key_ff > rd_a_ff) begin
               low_in   = EXT_W'(mid_ff) + EXT_W'(1);
               state_in = ST_BIN_RD;
            end else begin
               strobe_in = 1'b1;
               found_in  = 1'b1;
               pos_in    = POS_W'(mid_ff);
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      low_ff   <= low_in;
      high_ff  <= high_in;
      mid_ff   <= mid_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[IDX_W'(queue_in.item.index)] <= queue_in.item.data;
      end
      rd_a_ff <= table_mem[addr_a];
      rd_b_ff <= table_mem[addr_b];
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;

endmodule
`default_nettype wire

/* rtl/exponential_then_binary_search_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Exponential then binary search unit
// Loads a sorted table of signed words and looks keys up in it.
//
//   Channel   Handshake          Payload
//   request   start / busy       req_kind, req_entry_index, req_entry_value,
//                                req_search_key
//   response  rsp_strobe         rsp_found, rsp_position
//
// A load beat is written into the table while the engine is idle. A search runs
// doubling steps and then halving steps, each a read state and a compare state,
// and ends on a match, when doubling passes the table or when the halving phase
// runs dry. Each step waits on one registered read of the table memory.
// A two-beat queue sits between the front end and the engine, so busy rises
// only when it is full. Reset clears the control state but not the table.
// The response is shown for one cycle and cannot be held off.
// ---------------------------------------------------------------------------
module exponential_then_binary_search_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_kind,
   input  wire logic [etbs_pkg::POS_W-1:0]         req_entry_index,
   input  wire logic signed [etbs_pkg::DATA_W-1:0] req_entry_value,
   input  wire logic signed [etbs_pkg::DATA_W-1:0] req_search_key,
   output logic                                    rsp_strobe,
   output logic                                    rsp_found,
   output logic [etbs_pkg::POS_W-1:0]              rsp_position
);
   import etbs_pkg::*;

   queue_type queue_head;
   logic      queue_pop;

   etbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .queue_out       (queue_head),
      .queue_pop       (queue_pop)
   );

   etbs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_in     (queue_head),
      .queue_pop    (queue_pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

endmodule
`default_nettype wire
